[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clock, disabled while reset is high.
`define ASSERT_PROP(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must never be true on a clock edge outside of reset.
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

[rtl/icmper_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package icmper_pkg;

   localparam int MAX_PAYLOAD_BYTES = 32;
   localparam int HDR_BYTES         = 8;
   localparam int STORE_BYTES       = HDR_BYTES + MAX_PAYLOAD_BYTES;
   localparam int ADDR_W            = $clog2(STORE_BYTES);
   localparam int LEN_W             = $clog2(STORE_BYTES + 1);
   localparam int COUNT_W           = 7;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_W-1:0] STORE_CNT = COUNT_W'(STORE_BYTES);
   localparam logic [COUNT_W-1:0] HDR_CNT   = COUNT_W'(HDR_BYTES);
   localparam logic [7:0]         TYPE_ECHO_REQUEST = 8'd8;

   // result status codes
   localparam logic [2:0] ST_REPLY     = 3'd0;
   localparam logic [2:0] ST_TOO_SHORT = 3'd1;
   localparam logic [2:0] ST_BAD_SUM   = 3'd2;
   localparam logic [2:0] ST_TOO_LONG  = 3'd3;
   localparam logic [2:0] ST_NO_REPLY  = 3'd4;

   // outcome of one received message, passed from receive side to send side
   typedef struct packed {
      logic [2:0]       status;
      logic [LEN_W-1:0] len;
      logic [15:0]      cksum;
   } verdict_type;

   // 16-bit ones' complement add with end-around carry
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + 16'(s[16]);
   endfunction

endpackage

`default_nettype wire

[rtl/icmper_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module icmper_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 40
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while rd_en is low
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/icmper_rx.sv]
`timescale 1ns / 1ps
`default_nettype none

module icmper_rx
   import icmper_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,
   input  wire logic              req_tlast,
   input  wire logic              hold,
   output logic                   wr_en,
   output logic [ADDR_W-1:0]      wr_addr,
   output logic [7:0]             wr_data,
   output logic                   verdict_valid,
   input  wire logic              verdict_ack,
   output verdict_type            verdict
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [15:0]        sum_ff, sum_in;
   logic               ovf_ff, ovf_in;
   logic               busy_ff, busy_in;
   logic [7:0]         hdr_ff [4];

   logic               accept;
   logic               in_store;
   logic [15:0]        addend;
   logic [15:0]        calc;
   logic [15:0]        field;

   assign req_tready = !busy_ff && !hold;
   assign accept     = req_tvalid && req_tready;
   assign in_store   = count_ff < STORE_CNT;

   assign wr_en   = accept && in_store;
   assign wr_addr = count_ff[ADDR_W-1:0];
   assign wr_data = req_tdata;

   // even offset is the high half of its word
   assign addend = count_ff[0] ? {8'h00, req_tdata} : {req_tdata, 8'h00};

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      ovf_in   = ovf_ff;
      busy_in  = busy_ff;
      if (verdict_ack) begin
         count_in = '0;
         sum_in   = '0;
         ovf_in   = 1'b0;
         busy_in  = 1'b0;
      end else if (accept) begin
         if (count_ff != COUNT_MAX) begin
            count_in = count_ff + 1'b1;
         end
         if (in_store && count_ff >= COUNT_W'(4)) begin
            sum_in = oc_add(sum_ff, addend);
         end
         if (!in_store) begin
            ovf_in = 1'b1;
         end
         busy_in = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         ovf_ff   <= 1'b0;
         busy_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         ovf_ff   <= ovf_in;
         busy_ff  <= busy_in;
      end
   end

   // type, code and checksum field kept aside for the judgement
   always_ff @(posedge clock) begin
      if (accept && count_ff < COUNT_W'(4)) begin
         hdr_ff[count_ff[1:0]] <= req_tdata;
      end
   end

   assign calc  = ~oc_add(sum_ff, {hdr_ff[0], hdr_ff[1]});
   assign field = {hdr_ff[2], hdr_ff[3]};

   assign verdict_valid = busy_ff;

   always_comb begin
      verdict.len   = LEN_W'(count_ff);
      verdict.cksum = ~sum_ff;
      priority if (ovf_ff || count_ff > STORE_CNT) begin
         verdict.status = ST_TOO_LONG;
      end else if (count_ff < HDR_CNT) begin
         verdict.status = ST_TOO_SHORT;
      end else if (calc != field) begin
         verdict.status = ST_BAD_SUM;
      end else if (hdr_ff[0] != TYPE_ECHO_REQUEST) begin
         verdict.status = ST_NO_REPLY;
      end else begin
         verdict.status = ST_REPLY;
      end
   end

endmodule

`default_nettype wire

[rtl/icmper_tx.sv]
`timescale 1ns / 1ps
`default_nettype none

module icmper_tx
   import icmper_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              verdict_valid,
   output logic                   verdict_ack,
   input  wire verdict_type       verdict,
   output logic                   sending,
   output logic                   rd_en,
   output logic [ADDR_W-1:0]      rd_addr,
   input  wire logic [7:0]        rd_data,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast,
   output logic [2:0]             rsp_tuser
);

   logic              sending_ff;
   logic [ADDR_W-1:0] rd_idx_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [15:0]       ck_ff;

   // stage 1: RAM read data plus its offset
   logic              s1_valid_ff;
   logic [ADDR_W-1:0] s1_idx_ff;
   logic              s1_last_ff;

   logic              rsp_valid_ff;
   logic [7:0]        rsp_data_ff;
   logic              rsp_last_ff;
   logic [2:0]        rsp_user_ff;

   logic              out_free;
   logic              out_load;
   logic              issue;
   logic              rd_last;
   logic              take_verdict;
   logic              status_load;
   logic [7:0]        reply_byte;

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign out_load     = s1_valid_ff && out_free;
   assign issue        = sending_ff && (!s1_valid_ff || out_load);
   assign rd_last      = (LEN_W'(rd_idx_ff) + 1'b1) == len_ff;
   assign take_verdict = verdict_valid && !sending_ff && !s1_valid_ff &&
                         (verdict.status == ST_REPLY || out_free);
   assign status_load  = take_verdict && verdict.status != ST_REPLY;

   assign verdict_ack = take_verdict;
   assign sending     = sending_ff;
   assign rd_en       = issue;
   assign rd_addr     = rd_idx_ff;

   // reply header: type 0, code 0, fresh checksum
   always_comb begin
      unique case (s1_idx_ff)
         ADDR_W'(0), ADDR_W'(1): reply_byte = 8'h00;
         ADDR_W'(2):             reply_byte = ck_ff[15:8];
         ADDR_W'(3):             reply_byte = ck_ff[7:0];
         default:                reply_byte = rd_data;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take_verdict && verdict.status == ST_REPLY) begin
            sending_ff <= 1'b1;
         end else if (issue && rd_last) begin
            sending_ff <= 1'b0;
         end

         if (issue) begin
            s1_valid_ff <= 1'b1;
         end else if (out_load) begin
            s1_valid_ff <= 1'b0;
         end

         if (out_load || status_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_verdict) begin
         rd_idx_ff <= '0;
         len_ff    <= verdict.len;
         ck_ff     <= verdict.cksum;
      end else if (issue) begin
         rd_idx_ff <= rd_idx_ff + 1'b1;
      end

      if (issue) begin
         s1_idx_ff  <= rd_idx_ff;
         s1_last_ff <= rd_last;
      end

      if (out_load) begin
         rsp_data_ff <= reply_byte;
         rsp_last_ff <= s1_last_ff;
         rsp_user_ff <= ST_REPLY;
      end else if (status_load) begin
         rsp_data_ff <= 8'h00;
         rsp_last_ff <= 1'b1;
         rsp_user_ff <= verdict.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

[rtl/icmp_echo_responder.sv]
// ICMP echo responder.
// Input channel req_*: one ICMP message as bytes in network order, req_tlast on
// the final byte. Bytes are taken one per cycle, while req_tready is high, into
// a 40-entry message RAM while a ones' complement sum runs over offset 4 and up.
// Result channel rsp_*: rsp_tuser is the status (0 reply byte, 1 too short,
// 2 checksum bad, 3 too long, 4 accepted without reply). A dropped or silently
// accepted message gives one transfer with rsp_tdata 0 and rsp_tlast 1. A valid
// echo request is answered with the reply bytes, rsp_tlast on the last one.
// The status transfer is offered from the output register once the judgement is
// taken; reply bytes follow one per cycle while rsp_tready allows, from the RAM
// read port (registered read plus output register). After the final byte
// req_tready stays low for the judgement and, for an echo request that gets a
// reply, until the reply has been read out of the RAM.
// A stall on rsp_tready holds the output register and the RAM read stage; no
// data is lost. Synchronous reset clears all control state; RAM contents are
// left as they were and are never read before being written.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module icmp_echo_responder
   import icmper_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_byte
   input  wire logic       req_tlast,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic            rsp_tlast,
   output logic [2:0]      rsp_tuser    // [2:0] status
);

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic              verdict_valid;
   logic              verdict_ack;
   verdict_type       verdict;
   logic              sending;
   logic              status_xfer;
   logic              last_in;

   icmper_rx u_rx (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .hold          (sending),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .verdict_valid (verdict_valid),
      .verdict_ack   (verdict_ack),
      .verdict       (verdict)
   );

   icmper_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   icmper_tx u_tx (
      .clock         (clock),
      .reset         (reset),
      .verdict_valid (verdict_valid),
      .verdict_ack   (verdict_ack),
      .verdict       (verdict),
      .sending       (sending),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser)
   );

   assign status_xfer = rsp_tvalid && rsp_tuser != ST_REPLY;
   assign last_in     = req_tvalid && req_tready && req_tlast;

   // new message must not overwrite RAM entries still being replayed
   `ASSERT_NEVER(a_no_write_during_replay, wr_en && sending, "RAM written during replay")
   `ASSERT_NEVER(a_no_read_and_write, wr_en && rd_en, "RAM read and written together")
   `ASSERT_PROP(a_status_single, status_xfer |-> rsp_tlast && rsp_tdata == 8'h00, "bad status")
   `ASSERT_PROP(a_stop_after_last, last_in |=> !req_tready, "input taken before judgement")
   `ASSERT_PROP(a_ack_needs_valid, verdict_ack |-> verdict_valid, "verdict taken while not valid")

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import icmper_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 300;
   localparam int DRAIN_WAIT  = 12;
   localparam int SAT_LEN     = 128;
   localparam int MID_FILL    = 56;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } msg_byte_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
      logic [2:0] status;
   } echo_result_type;

   typedef enum {MSG_ECHO, MSG_CODED_ECHO, MSG_OTHER_TYPE, MSG_BAD_SUM, MSG_RAW} msg_kind_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] in_byte
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic       rsp_tlast;
   logic [2:0] rsp_tuser;           // [2:0] status

   msg_byte_type    wire_bytes[$];
   echo_result_type awaited[$];

   // receive-side shadow state
   logic [7:0]  rx_store[STORE_BYTES];
   logic [6:0]  rx_count;
   logic [15:0] rx_sum;
   logic        rx_overflow;

   int send_idle_pct = 22;
   int recv_idle_pct = 64;
   int phase = 0;
   int hold_left = 0;
   bit long_hold_done = 1'b0;
   int fail_count = 0;
   int cycles = 0;
   int bytes_queued = 0;

   icmp_echo_responder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // end-around carry add
   function automatic logic [15:0] fold16(input logic [15:0] a, input logic [15:0] b);
      int s;
      s = int'(a) + int'(b);
      if (s > 'hffff) s -= 'hffff;
      return s[15:0];
   endfunction

   function automatic void absorb_byte(input logic [7:0] b, input logic fin);
      logic [2:0]  verdict;
      logic [15:0] calc;
      logic [15:0] ck;
      logic [7:0]  data;
      int n;
      if (rx_count < STORE_BYTES) begin
         rx_store[rx_count] = b;
         // even offsets are the high half of a word
         if (rx_count >= 4)
            rx_sum = fold16(rx_sum, rx_count[0] ? {8'h00, b} : {b, 8'h00});
      end else begin
         rx_overflow = 1'b1;
      end
      if (rx_count != 7'h7f) rx_count++;
      if (!fin) return;

      n = rx_count;
      if (rx_overflow || n > STORE_BYTES) begin
         verdict = ST_TOO_LONG;
      end else if (n < HDR_BYTES) begin
         verdict = ST_TOO_SHORT;
      end else begin
         calc = ~fold16(rx_sum, {rx_store[0], rx_store[1]});
         if (calc != {rx_store[2], rx_store[3]}) verdict = ST_BAD_SUM;
         else if (rx_store[0] != TYPE_ECHO_REQUEST) verdict = ST_NO_REPLY;
         else verdict = ST_REPLY;
      end

      if (verdict != ST_REPLY) begin
         awaited.push_back('{8'h00, 1'b1, verdict});
      end else begin
         ck = ~rx_sum;
         for (int i = 0; i < n; i++) begin
            if (i < 2) data = 8'h00;
            else if (i == 2) data = ck[15:8];
            else if (i == 3) data = ck[7:0];
            else data = rx_store[i];
            awaited.push_back('{data, i == n - 1, ST_REPLY});
         end
      end
      rx_count = '0;
      rx_sum = '0;
      rx_overflow = 1'b0;
   endfunction

   task automatic add_message(input msg_kind_type kind, input int len);
      logic [7:0]  m[$];
      logic [15:0] sum;
      logic [7:0]  kind_code;
      for (int i = 0; i < len; i++) m.push_back(8'($urandom_range(255)));
      if (kind != MSG_RAW && len >= HDR_BYTES) begin
         kind_code = TYPE_ECHO_REQUEST;
         if (kind == MSG_OTHER_TYPE)
            while (kind_code == TYPE_ECHO_REQUEST) kind_code = 8'($urandom_range(255));
         m[0] = kind_code;
         m[1] = (kind == MSG_CODED_ECHO) ? 8'($urandom_range(1, 255)) : 8'h00;
         sum = '0;
         for (int i = 4; i < len; i += 2)
            sum = fold16(sum, {m[i], (i + 1 < len) ? m[i + 1] : 8'h00});
         sum = ~fold16(sum, {m[0], m[1]});
         m[2] = sum[15:8];
         m[3] = sum[7:0];
         if (kind == MSG_BAD_SUM) m[2 + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
      end
      for (int i = 0; i < len; i++) wire_bytes.push_back('{m[i], i == len - 1});
      bytes_queued += len;
   endtask

   task automatic add_random_message();
      int r;
      r = $urandom_range(99);
      if (r < 55)
         add_message(MSG_ECHO, ($urandom_range(9) == 0) ? STORE_BYTES : $urandom_range(8, 24));
      else if (r < 63) add_message(MSG_CODED_ECHO, $urandom_range(8, 20));
      else if (r < 72) add_message(MSG_OTHER_TYPE, $urandom_range(8, 20));
      else if (r < 84) add_message(MSG_BAD_SUM, $urandom_range(8, 20));
      else if (r < 93) add_message(MSG_RAW, $urandom_range(1, HDR_BYTES - 1));
      else add_message(MSG_ECHO, $urandom_range(STORE_BYTES + 1, 60));
   endtask

   // sender: drives req_* and feeds accepted bytes into the shadow state
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rx_count = '0;
         rx_sum = '0;
         rx_overflow = 1'b0;
      end else begin
         if (req_tvalid && req_tready) absorb_byte(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (wire_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= wire_bytes[0].data;
               req_tlast <= wire_bytes[0].last;
               void'(wire_bytes.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stalls plus one long hold-off in the last phase
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (phase == 2 && !long_hold_done) begin
         long_hold_done = 1'b1;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      echo_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited.size() == 0) begin
            $error("unexpected transfer: out_byte %0h out_last %0b status %0d",
                   rsp_tdata, rsp_tlast, rsp_tuser);
            fail_count++;
         end else begin
            exp_r = awaited.pop_front();
            if (rsp_tdata !== exp_r.data) begin
               $error("out_byte: expected %0h, got %0h", exp_r.data, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== exp_r.last) begin
               $error("out_last: expected %0b, got %0b", exp_r.last, rsp_tlast);
               fail_count++;
            end
            if (rsp_tuser !== exp_r.status) begin
               $error("status: expected %0d, got %0d", exp_r.status, rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("icmp_echo_responder verification failed");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < 3; p++) begin
         @(negedge clock);
         phase = p;
         send_idle_pct = (p == 0) ? 22 : (p == 1) ? 64 : 0;
         recv_idle_pct = (p == 0) ? 64 : (p == 1) ? 22 : 0;
         bytes_queued = 0;
         if (p == 0) begin
            add_message(MSG_RAW, 1);
            add_message(MSG_RAW, HDR_BYTES - 1);
            add_message(MSG_ECHO, HDR_BYTES);
            add_message(MSG_ECHO, HDR_BYTES + 1);     // odd tail byte padded
            add_message(MSG_CODED_ECHO, HDR_BYTES);
            add_message(MSG_OTHER_TYPE, HDR_BYTES);
            add_message(MSG_BAD_SUM, HDR_BYTES);
         end else if (p == 1) begin
            add_message(MSG_ECHO, STORE_BYTES);       // store exactly full
            while (bytes_queued < MID_FILL) add_random_message();
         end else begin
            add_message(MSG_ECHO, SAT_LEN);           // byte count saturates
            add_message(MSG_ECHO, HDR_BYTES);         // waits out the long hold
         end
         while (wire_bytes.size() > 0 || req_tvalid || awaited.size() > 0)
            @(negedge clock);
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0 && awaited.size() == 0) begin
         $display("icmp_echo_responder verification clean");
      end else begin
         $display("icmp_echo_responder verification failed");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/icmper_pkg.sv
rtl/icmper_ram.sv
rtl/icmper_rx.sv
rtl/icmper_tx.sv
rtl/icmp_echo_responder.sv
bench/testbench.sv
